>>> rtl/core/lrg_pkg.sv
// Shared types and constants for the line raster generator.
// Holds the item structs and the controller/datapath command and status groups.
// No dependencies.
package lrg_pkg;

  // Fixed field widths of the request and pixel items.
  localparam int COORD_W = 6;
  localparam int CODE_W = 8;

  // Default number of coordinate bits that take part in the arithmetic.
  localparam int COORD_BITS_DEF = 6;

  // One line request.
  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [CODE_W-1:0]  fill_code;
  } lrg_in_t;

  // One plotted pixel.
  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [CODE_W-1:0]  plot_code;
    logic               last_pixel;
  } lrg_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
  } lrg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic load_last;
    logic step_last;
  } lrg_sts_t;

endpackage

>>> rtl/core/lrg_ctrl.sv
// Controller state machine of the line raster generator.
// Sequences loading and stepping of the datapath; uses lrg_pkg.
module lrg_ctrl
  import lrg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output lrg_cmd_t cmd,
  input  lrg_sts_t sts
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_STEP = 2'b10
  } lrg_state_t;

  lrg_state_t state_r;
  lrg_state_t state_nxt;

  // Commands follow directly from the state and the start request.
  assign busy     = (state_r == ST_STEP);
  assign cmd.load = start && (state_r == ST_IDLE);
  assign cmd.step = (state_r == ST_STEP);

  // Next-state logic: a line whose start is its end needs no stepping.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start && !sts.load_last) begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        if (sts.step_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/core/lrg_dpath.sv
// Datapath of the line raster generator: position, error term and pixel output.
// Driven by lrg_ctrl through command and status structs; uses lrg_pkg.
module lrg_dpath
  import lrg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  lrg_cmd_t cmd,
  output lrg_sts_t sts,
  input  lrg_in_t  in_item,
  output logic     out_valid,
  output lrg_out_t out_item
);

  localparam int CB = COORD_BITS;
  localparam int EW = COORD_BITS + 3;
  localparam int CW = COORD_BITS + 1;
  localparam int MaxPix = 1 << COORD_BITS;

  // Request decode for loading.
  logic [CB-1:0] xs, ys, xe, ye;
  logic          xpos, ypos, xmaj;
  logic [CB-1:0] adx, ady, dmaj, dmin;
  logic [CB-1:0] maj_s, maj_e, min_s;
  logic signed [EW-1:0] err0;

  // Line state.
  logic                 swap_r;
  logic [CB-1:0]        maj_r, min_r, maj_end_r;
  logic                 maj_up_r, min_up_r;
  logic signed [EW-1:0] dmaj2_r, dmin2_r, err_r;
  logic [CW-1:0]        cnt_r;
  logic [CODE_W-1:0]    code_r;

  // Step results.
  logic                 emit;
  logic [CB-1:0]        maj_step, min_step;
  logic [CW-1:0]        cnt_inc;
  logic                 step_end;

  // Output registers.
  logic                 out_valid_r;
  logic [CB-1:0]        px_r, py_r;
  logic [CODE_W-1:0]    pcode_r;
  logic                 plast_r;

  // Work out direction, major axis and the starting error from the request.
  always_comb begin
    xs    = in_item.start_x[CB-1:0];
    ys    = in_item.start_y[CB-1:0];
    xe    = in_item.end_x[CB-1:0];
    ye    = in_item.end_y[CB-1:0];
    xpos  = xe > xs;
    ypos  = ye > ys;
    adx   = xpos ? (xe - xs) : (xs - xe);
    ady   = ypos ? (ye - ys) : (ys - ye);
    xmaj  = adx > ady;
    dmaj  = xmaj ? adx : ady;
    dmin  = xmaj ? ady : adx;
    maj_s = xmaj ? xs : ys;
    maj_e = xmaj ? xe : ye;
    min_s = xmaj ? ys : xs;
    err0  = EW'({dmin, 1'b0}) - EW'(dmaj);
  end

  // One step: a negative error moves along the major axis and plots.
  always_comb begin
    emit     = err_r[EW-1];
    maj_step = maj_up_r ? (maj_r + CB'(1)) : (maj_r - CB'(1));
    min_step = min_up_r ? (min_r + CB'(1)) : (min_r - CB'(1));
    cnt_inc  = cnt_r + CW'(1);
    step_end = (maj_step == maj_end_r) || (cnt_inc == CW'(MaxPix));
  end

  assign sts.load_last = (maj_s == maj_e);
  assign sts.step_last = cmd.step && emit && step_end;

  // Line state registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      swap_r    <= !xmaj;
      maj_r     <= maj_s;
      min_r     <= min_s;
      maj_end_r <= maj_e;
      maj_up_r  <= xmaj ? xpos : ypos;
      min_up_r  <= xmaj ? ypos : xpos;
      dmaj2_r   <= EW'({dmaj, 1'b0});
      dmin2_r   <= EW'({dmin, 1'b0});
      err_r     <= err0;
      cnt_r     <= CW'(1);
      code_r    <= in_item.fill_code;
    end else if (cmd.step) begin
      if (emit) begin
        maj_r <= maj_step;
        err_r <= err_r + dmin2_r;
        cnt_r <= cnt_inc;
      end else begin
        min_r <= min_step;
        err_r <= err_r - dmaj2_r;
      end
    end
  end

  // Pixel strobe: the start point on load, then each major-axis step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.load || (cmd.step && emit);
    end
  end

  // Pixel payload.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_r    <= xs;
      py_r    <= ys;
      pcode_r <= in_item.fill_code;
      plast_r <= sts.load_last;
    end else if (cmd.step && emit) begin
      px_r    <= swap_r ? min_r : maj_step;
      py_r    <= swap_r ? maj_step : min_r;
      pcode_r <= code_r;
      plast_r <= step_end;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_item.pixel_x    = COORD_W'(px_r);
  assign out_item.pixel_y    = COORD_W'(py_r);
  assign out_item.plot_code  = pcode_r;
  assign out_item.last_pixel = plast_r;

endmodule

>>> rtl/core/line_raster_generator_unit.sv
// Top level of the line raster generator.
// Instantiates lrg_ctrl and lrg_dpath; uses lrg_pkg.
//
// A request is taken when start is high and busy is low; its start point
// is registered and appears on the output in the next cycle. After that
// the datapath takes one step of the error term per cycle: a step along
// the major axis puts the next pixel out, a step along the minor axis
// only moves the position. Busy stays high while a line is stepped. The
// minor steps never outnumber the major ones, so a full diagonal is the
// longest line to step. The next request may be given in the cycle busy
// falls. Pixels are presented for exactly one cycle with out_valid high
// and cannot be held off; the last pixel of each line carries last_pixel.
module line_raster_generator_unit
  import lrg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  lrg_in_t  in_item,
  output logic     out_valid,
  output lrg_out_t out_item
);

  lrg_cmd_t cmd;
  lrg_sts_t sts;

  // Sequencing.
  lrg_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  // Stepping and pixel output.
  lrg_dpath #(
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

>>> dv/line_raster_generator_unit_test.sv
// Self-checking testbench for line_raster_generator_unit: drives line requests
// and checks every plotted pixel against a predicted Bresenham line.
// Depends on lrg_pkg and the RTL of line_raster_generator_unit.
module line_raster_generator_unit_test
  import lrg_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_MAX = (1 << COORD_W) - 1;
  localparam int PIXEL_CAP = 1 << COORD_BITS_DEF;
  localparam int STEP_GUARD = 4 * PIXEL_CAP;
  localparam int RANDOM_LINES = 157;
  localparam int DRAIN_LIMIT = 2000;

  // Holds the pixels still owed by the block and checks each one that appears.
  class line_pixel_checker;
    lrg_out_t expected_pixels[$];
    int mismatches = 0;

    task report_mismatch(string what);
      $display("%0t ns: mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    function void add_pixel(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                            logic [CODE_W-1:0] code);
      lrg_out_t pix;
      pix.pixel_x = px;
      pix.pixel_y = py;
      pix.plot_code = code;
      pix.last_pixel = 1'b0;
      expected_pixels.push_back(pix);
    endfunction

    // Works out the pixels of one accepted line and queues them in order.
    function void note_request(lrg_in_t req);
      logic [COORD_W-1:0] px;
      logic [COORD_W-1:0] py;
      int start_x;
      int start_y;
      int end_x;
      int end_y;
      int dx;
      int dy;
      int err;
      int count;
      int guard;
      bit x_up;
      bit y_up;
      px = req.start_x;
      py = req.start_y;
      start_x = int'(req.start_x);
      start_y = int'(req.start_y);
      end_x = int'(req.end_x);
      end_y = int'(req.end_y);
      dx = end_x - start_x;
      dy = end_y - start_y;
      x_up = dx > 0;
      y_up = dy > 0;
      if (!x_up) dx = -dx;
      if (!y_up) dy = -dy;
      guard = 0;
      // The start point is always plotted.
      add_pixel(px, py, req.fill_code);
      count = 1;
      if (dx > dy) begin
        // Shallow line: only column steps plot a pixel.
        err = 2 * dy - dx;
        while (px != req.end_x && guard < STEP_GUARD && count < PIXEL_CAP) begin
          guard++;
          if (err < 0) begin
            px = x_up ? px + COORD_W'(1) : px - COORD_W'(1);
            err += 2 * dy;
            add_pixel(px, py, req.fill_code);
            count++;
          end else begin
            py = y_up ? py + COORD_W'(1) : py - COORD_W'(1);
            err -= 2 * dx;
          end
        end
      end else begin
        // Steep or diagonal line: only row steps plot a pixel.
        err = 2 * dx - dy;
        while (py != req.end_y && guard < STEP_GUARD && count < PIXEL_CAP) begin
          guard++;
          if (err < 0) begin
            py = y_up ? py + COORD_W'(1) : py - COORD_W'(1);
            err += 2 * dx;
            add_pixel(px, py, req.fill_code);
            count++;
          end else begin
            px = x_up ? px + COORD_W'(1) : px - COORD_W'(1);
            err -= 2 * dy;
          end
        end
      end
      expected_pixels[expected_pixels.size() - 1].last_pixel = 1'b1;
    endfunction

    // Compares one pixel from the block with the oldest pixel owed.
    task check_pixel(lrg_out_t got);
      lrg_out_t want;
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel (%0d,%0d) code %0d last %0b",
                                  got.pixel_x, got.pixel_y, got.plot_code,
                                  got.last_pixel));
        return;
      end
      want = expected_pixels.pop_front();
      if (got.pixel_x != want.pixel_x)
        report_mismatch($sformatf("pixel_x %0d, expected %0d", got.pixel_x,
                                  want.pixel_x));
      if (got.pixel_y != want.pixel_y)
        report_mismatch($sformatf("pixel_y %0d, expected %0d", got.pixel_y,
                                  want.pixel_y));
      if (got.plot_code != want.plot_code)
        report_mismatch($sformatf("plot_code %0d, expected %0d", got.plot_code,
                                  want.plot_code));
      if (got.last_pixel != want.last_pixel)
        report_mismatch($sformatf("last_pixel %0b, expected %0b at (%0d,%0d)",
                                  got.last_pixel, want.last_pixel,
                                  want.pixel_x, want.pixel_y));
    endtask
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  lrg_in_t  in_item = '0;
  logic     out_valid;
  lrg_out_t out_item;

  line_pixel_checker board = new();

  line_raster_generator_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always #10 clk = ~clk;

  // Watch both channels at every edge: note accepted items, check pixels.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) board.note_request(in_item);
      if (out_valid) board.check_pixel(out_item);
    end
  end

  function automatic lrg_in_t make_line(int sx, int sy, int ex, int ey, int code);
    lrg_in_t req;
    req.start_x = COORD_W'(sx);
    req.start_y = COORD_W'(sy);
    req.end_x = COORD_W'(ex);
    req.end_y = COORD_W'(ey);
    req.fill_code = CODE_W'(code);
    return req;
  endfunction

  function automatic int clamp_coord(int v);
    if (v < 0) return 0;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  function automatic int edge_coord();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return COORD_MAX;
      default: return $urandom_range(0, COORD_MAX);
    endcase
  endfunction

  // Random line of one of several shapes: anything, short, straight, at the border.
  function automatic lrg_in_t random_line();
    int sx;
    int sy;
    int ex;
    int ey;
    int span;
    sx = $urandom_range(0, COORD_MAX);
    sy = $urandom_range(0, COORD_MAX);
    ex = $urandom_range(0, COORD_MAX);
    ey = $urandom_range(0, COORD_MAX);
    case ($urandom_range(0, 3))
      1: begin
        ex = clamp_coord(sx + $urandom_range(0, 10) - 5);
        ey = clamp_coord(sy + $urandom_range(0, 10) - 5);
      end
      2: begin
        case ($urandom_range(0, 2))
          0: ey = sy;
          1: ex = sx;
          default: begin
            span = (ex > sx) ? ex - sx : sx - ex;
            if (sy + span <= COORD_MAX && (sy < span || $urandom_range(0, 1)))
              ey = sy + span;
            else if (sy >= span)
              ey = sy - span;
            else
              ey = sy;
          end
        endcase
      end
      3: begin
        sx = edge_coord();
        sy = edge_coord();
        ex = edge_coord();
        ey = edge_coord();
      end
      default: ;
    endcase
    return make_line(sx, sy, ex, ey, $urandom_range(0, 255));
  endfunction

  // Offers one item after an optional pause and returns at the edge that takes it.
  task automatic send_line(lrg_in_t req, int gap, bit settle);
    if (gap > 0 || settle) begin
      start <= 1'b0;
      if (settle) begin
        do @(posedge clk); while (busy);
      end
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (busy);
  endtask

  initial begin
    lrg_in_t directed[$];
    int gap;
    int spin;
    bit calm;
    bit settle;

    // Zero-length lines, full-length straight lines, diagonals and error ties.
    directed.push_back(make_line(0, 0, 0, 0, 8'h00));
    directed.push_back(make_line(63, 63, 63, 63, 8'hFF));
    directed.push_back(make_line(0, 0, 63, 0, 8'hA5));
    directed.push_back(make_line(63, 5, 0, 5, 8'h5A));
    directed.push_back(make_line(7, 0, 7, 63, 8'h01));
    directed.push_back(make_line(9, 63, 9, 0, 8'h80));
    directed.push_back(make_line(0, 0, 63, 63, 8'h7F));
    directed.push_back(make_line(63, 0, 0, 63, 8'hFE));
    directed.push_back(make_line(0, 63, 63, 0, 8'hFF));
    directed.push_back(make_line(10, 10, 2, 2, 8'h3C));
    directed.push_back(make_line(1, 0, 0, 1, 8'hC3));
    directed.push_back(make_line(0, 0, 2, 1, 8'h11));
    directed.push_back(make_line(0, 0, 1, 2, 8'h22));
    directed.push_back(make_line(0, 0, 5, 4, 8'h33));
    directed.push_back(make_line(63, 0, 0, 0, 8'h44));
    // One line into each octant from a common centre.
    directed.push_back(make_line(32, 32, 40, 35, 8'h55));
    directed.push_back(make_line(32, 32, 35, 40, 8'h66));
    directed.push_back(make_line(32, 32, 24, 35, 8'h77));
    directed.push_back(make_line(32, 32, 29, 40, 8'h88));
    directed.push_back(make_line(32, 32, 40, 29, 8'h99));
    directed.push_back(make_line(32, 32, 35, 24, 8'hAA));
    directed.push_back(make_line(32, 32, 24, 29, 8'hBB));
    directed.push_back(make_line(32, 32, 29, 24, 8'hCC));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_line(directed[i], $urandom_range(0, 8), 1'b0);

    // Random lines; some stretches run back to back, others pause or drain first.
    calm = 1'b0;
    for (int i = 0; i < RANDOM_LINES; i++) begin
      if (i % 30 == 0) calm = ($urandom_range(0, 3) == 0);
      gap = calm ? 0 : $urandom_range(0, 8);
      settle = !calm && ($urandom_range(0, 3) == 0);
      send_line(random_line(), gap, settle);
    end
    start <= 1'b0;

    // Let the last line finish, then a few spare cycles for stray pixels.
    spin = 0;
    while (board.expected_pixels.size() > 0 && spin < DRAIN_LIMIT) begin
      @(posedge clk);
      spin++;
    end
    repeat (8) @(posedge clk);
    if (board.expected_pixels.size() > 0)
      board.report_mismatch($sformatf("%0d pixels never appeared",
                                      board.expected_pixels.size()));

    if (board.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #6_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> line_raster_generator_unit.f
rtl/core/lrg_pkg.sv
rtl/core/lrg_ctrl.sv
rtl/core/lrg_dpath.sv
rtl/core/line_raster_generator_unit.sv
dv/line_raster_generator_unit_test.sv
